[rtl/pdd_pkg.sv]
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types, widths, register indexes and defaults for the dart-throwing
// Poisson-disk acceptor.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// Fixed field widths of the request and result
	localparam int FIELD_W    = 16;
	localparam int NUM_FIELDS = 4;
	localparam int SLOT_W     = 10;
	localparam int COUNT_W    = 11;
	localparam int FAIL_W     = 16;

	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	// Configuration registers
	localparam int MIN_DIST_W = 35;
	localparam int LIMIT_W    = 16;
	localparam int TARGET_W   = 11;
	localparam int DIMS_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MIN_DIST_W;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 2'd3;

	localparam logic [MIN_DIST_W-1:0] RST_MIN_DIST = '0;
	localparam logic [LIMIT_W-1:0]    RST_LIMIT    = '0;
	localparam logic [TARGET_W-1:0]   RST_TARGET   = 11'd1024;
	localparam logic [DIMS_W-1:0]     RST_DIMS     = 3'd2;

	// Default parameter values
	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int DEF_MAX_DIMS    = 4;
	localparam int DEF_COORD_BITS  = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] coord_x;
		logic [FIELD_W-1:0] coord_y;
		logic [FIELD_W-1:0] coord_z;
		logic [FIELD_W-1:0] coord_w;
	} pdd_req_t;

	typedef struct packed {
		logic               accepted;
		logic [SLOT_W-1:0]  slot_index;
		logic [COUNT_W-1:0] count_now;
		logic [FAIL_W-1:0]  failures_now;
		logic               finished;
	} pdd_res_t;

endpackage

[rtl/pdd_store.sv]
// ----------------------------------------------------------------------------
// pdd_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdd_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/pdd_cell.sv]
// ----------------------------------------------------------------------------
// pdd_cell
// One coordinate of the distance chain: squares the difference between the
// lowest coordinate of the passing sample and its candidate coordinate, adds
// it to the running sum and hands the shifted sample to the next cell.
// ----------------------------------------------------------------------------
module pdd_cell #(
	parameter int COORD_BITS = 16,
	parameter int NDIM       = 4,
	parameter int DIST_W     = 34
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [COORD_BITS-1:0]      coord,
	input  logic                       in_valid,
	input  logic [NDIM*COORD_BITS-1:0] in_sample,
	input  logic [DIST_W-1:0]          in_dist,
	output logic                       out_valid,
	output logic [NDIM*COORD_BITS-1:0] out_sample,
	output logic [DIST_W-1:0]          out_dist
);

	localparam int SW   = NDIM * COORD_BITS;
	localparam int SQ_W = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] own;
	logic [COORD_BITS-1:0] diff;
	logic                  valid_s1;
	logic [SQ_W-1:0]       sq_s1;
	logic [DIST_W-1:0]     dist_s1;
	logic [SW-1:0]         sample_s1;
	logic                  valid_s2;
	logic [DIST_W-1:0]     dist_s2;
	logic [SW-1:0]         sample_s2;

	assign own  = in_sample[COORD_BITS-1:0];
	assign diff = (own >= coord) ? (own - coord) : (coord - own);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1     <= en ? (SQ_W'(diff) * SQ_W'(diff)) : '0;
		dist_s1   <= in_dist;
		sample_s1 <= in_sample >> COORD_BITS;
		dist_s2   <= dist_s1 + DIST_W'(sq_s1);
		sample_s2 <= sample_s1;
	end

	assign out_valid  = valid_s2;
	assign out_sample = sample_s2;
	assign out_dist   = dist_s2;

endmodule

[rtl/poisson_disk_dart_throwing.sv]
// ----------------------------------------------------------------------------
// poisson_disk_dart_throwing
// Dart-throwing Poisson-disk acceptor: checks each candidate point against
// all stored samples and keeps it when no sample lies closer than the
// configured minimum spacing.
// ----------------------------------------------------------------------------
// One request at a time. A request streams the stored samples out of the
// sample memory, one per cycle, through a chain of D distance cells
// (D = min(MAX_DIMS, 4), two register stages each), then drains the chain and
// decides; with no stored sample it goes straight to the decision, and after
// the run has finished straight to the result. The memory read port sets the
// one-sample-per-cycle scan. The result sits in an output register, so the
// next request is taken while a result still waits. Configuration writes are
// always ready and act at once, also on a request in progress.
// ----------------------------------------------------------------------------
module poisson_disk_dart_throwing #(
	parameter int MAX_SAMPLES = pdd_pkg::DEF_MAX_SAMPLES,
	parameter int MAX_DIMS    = pdd_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS  = pdd_pkg::DEF_COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cand_valid,
	output logic                               cand_ready,
	input  pdd_pkg::pdd_req_t                  cand,
	output logic                               res_valid,
	input  logic                               res_ready,
	output pdd_pkg::pdd_res_t                  res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import pdd_pkg::*;

	localparam int NDIM    = (MAX_DIMS < NUM_FIELDS) ? MAX_DIMS : NUM_FIELDS;
	localparam int SW      = NDIM * COORD_BITS;
	localparam int AW      = $clog2(MAX_SAMPLES);
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int DIST_W  = 2 * COORD_BITS + 2;
	localparam int CMP_W   = (DIST_W > MIN_DIST_W) ? DIST_W : MIN_DIST_W;
	localparam int TC_W    = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
	localparam int DRAIN_N = 2 * NDIM;
	localparam int DRN_W   = $clog2(DRAIN_N + 1);

	localparam logic [TC_W-1:0]   CAP      = TC_W'(MAX_SAMPLES);
	localparam logic [DIMS_W-1:0] DIMS_TOP = DIMS_W'(NDIM);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	// Configuration registers
	logic [MIN_DIST_W-1:0] min_dist_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [TARGET_W-1:0]   target_q;
	logic [DIMS_W-1:0]     dims_q;

	// Control
	logic [2:0]       state_q;
	logic [AW-1:0]    rd_addr_q;
	logic [DRN_W-1:0] drain_q;
	logic [CNT_W-1:0] count_q;
	logic [FAIL_W-1:0] fail_q;
	logic             hit_q;
	logic             acc_q;
	logic [AW-1:0]    slot_q;
	logic [SW-1:0]    cand_q;
	logic             res_valid_q;
	pdd_res_t         res_q;

	logic             accept;
	logic             run_done;
	logic [DIMS_W-1:0] eff_dims;
	logic [NDIM-1:0]  dim_en;
	logic [SW-1:0]    cand_masked;
	logic             rd_en;
	logic             wr_en;
	logic             rd_valid_s1;
	logic [SW-1:0]    rd_data;
	logic             last_addr;
	logic             res_free;

	logic [FIELD_W-1:0]          fld [NUM_FIELDS];
	logic [SLOT_W+AW-1:0]        slot_ext;
	logic [COUNT_W+CNT_W-1:0]    count_ext;

	// Chain links
	logic [NDIM:0]     lk_valid;
	logic [SW-1:0]     lk_sample [NDIM+1];
	logic [DIST_W-1:0] lk_dist   [NDIM+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= RST_MIN_DIST;
			limit_q    <= RST_LIMIT;
			target_q   <= RST_TARGET;
			dims_q     <= RST_DIMS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_DIST: min_dist_q <= cfg_data;
				REG_LIMIT:    limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_TARGET:   target_q   <= cfg_data[TARGET_W-1:0];
				REG_DIMS:     dims_q     <= cfg_data[DIMS_W-1:0];
			endcase
		end
	end

	// Clamp dims to 1..NDIM and enable the lowest cells
	always_comb begin
		if (dims_q == '0) begin
			eff_dims = DIMS_W'(1);
		end else if (dims_q > DIMS_TOP) begin
			eff_dims = DIMS_TOP;
		end else begin
			eff_dims = dims_q;
		end
	end

	assign run_done = (TC_W'(count_q) >= TC_W'(target_q)) || (TC_W'(count_q) >= CAP) ||
		((limit_q != '0) && (fail_q >= limit_q));

	// Mask each field to COORD_BITS
	assign fld[0] = cand.coord_x;
	assign fld[1] = cand.coord_y;
	assign fld[2] = cand.coord_z;
	assign fld[3] = cand.coord_w;

	for (genvar k = 0; k < NDIM; k++) begin : g_mask
		logic [FIELD_W+COORD_BITS-1:0] ext;
		assign ext = {{COORD_BITS{1'b0}}, fld[k]};
		assign cand_masked[k*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
		assign dim_en[k] = DIMS_W'(k) < eff_dims;
	end

	assign cand_ready = (state_q == S_IDLE);
	assign accept     = cand_valid && cand_ready;
	assign rd_en      = (state_q == S_SCAN);
	assign wr_en      = (state_q == S_DECIDE) && !hit_q;
	assign last_addr  = (CNT_W'(rd_addr_q) + 1'b1) == count_q;
	assign res_free   = !res_valid_q || res_ready;

	pdd_store #(
		.DEPTH (MAX_SAMPLES),
		.WIDTH (SW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(count_q)),
		.wr_data (cand_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	assign lk_valid[0]  = rd_valid_s1;
	assign lk_sample[0] = rd_data;
	assign lk_dist[0]   = '0;

	for (genvar k = 0; k < NDIM; k++) begin : g_cell
		pdd_cell #(
			.COORD_BITS (COORD_BITS),
			.NDIM       (NDIM),
			.DIST_W     (DIST_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (dim_en[k]),
			.coord      (cand_q[k*COORD_BITS +: COORD_BITS]),
			.in_valid   (lk_valid[k]),
			.in_sample  (lk_sample[k]),
			.in_dist    (lk_dist[k]),
			.out_valid  (lk_valid[k+1]),
			.out_sample (lk_sample[k+1]),
			.out_dist   (lk_dist[k+1])
		);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_addr_q <= '0;
			drain_q   <= '0;
			count_q   <= '0;
			fail_q    <= '0;
			hit_q     <= 1'b0;
			acc_q     <= 1'b0;
			slot_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q     <= 1'b0;
						rd_addr_q <= '0;
						acc_q     <= 1'b0;
						slot_q    <= '0;
						if (run_done) begin
							state_q <= S_RESULT;
						end else if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last_addr) begin
						drain_q <= DRN_W'(DRAIN_N);
						state_q <= S_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// wait for the last sample to leave the chain
					if (drain_q == '0) begin
						state_q <= S_DECIDE;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				S_DECIDE: begin
					if (!hit_q) begin
						acc_q   <= 1'b1;
						slot_q  <= AW'(count_q);
						count_q <= count_q + 1'b1;
						fail_q  <= '0;
					end else if (fail_q != FAIL_MAX) begin
						fail_q <= fail_q + 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// any distance below the spacing rejects the candidate
			if (lk_valid[NDIM] && (CMP_W'(lk_dist[NDIM]) < CMP_W'(min_dist_q))) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= cand_masked;
		end
	end

	// Output register
	assign slot_ext  = {{SLOT_W{1'b0}}, slot_q};
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && res_free) begin
			res_q.accepted     <= acc_q;
			res_q.slot_index   <= slot_ext[SLOT_W-1:0];
			res_q.count_now    <= count_ext[COUNT_W-1:0];
			res_q.failures_now <= fail_q;
			res_q.finished     <= run_done;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dart-throwing Poisson-disk acceptor. A queue of
// candidate points feeds a valid/ready driver; every accepted request runs
// through a local copy of the acceptor (sample store, counts, registers) and
// the expected verdict is matched field by field against each result taken
// by a stalling monitor. Directed points cover the corners, then random
// phases with fresh register settings go on until 580 requests have been sent.
// ----------------------------------------------------------------------------
module testbench;
	import pdd_pkg::*;

	localparam int PERIOD      = 4;
	localparam int ITEM_GOAL   = 580;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int AXES_TOP    = (DEF_MAX_DIMS < NUM_FIELDS) ? DEF_MAX_DIMS : NUM_FIELDS;

	localparam logic [CFG_DATA_W-1:0] DIST_TOP = 35'h4_0000_0000;

	typedef logic [0:NUM_FIELDS-1][FIELD_W-1:0] point_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cand_valid = 1'b0;
	logic                  cand_ready;
	pdd_req_t              cand       = '0;
	logic                  res_valid;
	logic                  res_ready  = 1'b0;
	pdd_res_t              res;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// Local copy of the acceptor's registers and state
	logic [MIN_DIST_W-1:0] min_gap_sq = RST_MIN_DIST;
	logic [LIMIT_W-1:0]    fail_cap   = RST_LIMIT;
	logic [TARGET_W-1:0]   target_reg = RST_TARGET;
	logic [DIMS_W-1:0]     dims_reg   = RST_DIMS;
	point_t                sites [DEF_MAX_SAMPLES];
	logic [COUNT_W-1:0]    stored_count = '0;
	logic [FAIL_W-1:0]     reject_run   = '0;

	pdd_req_t cand_pending [$];
	pdd_res_t verdicts_due [$];

	bit cand_live;
	int cand_gap;
	int cand_calm;
	int hold_cycles;
	int res_calm;
	int items_sent;
	int mismatches;
	int cycle_count;

	poisson_disk_dart_throwing uut (
		.clk, .arst_n,
		.cand_valid, .cand_ready, .cand,
		.res_valid, .res_ready, .res,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("poisson_disk_dart_throwing test failed");
			$finish;
		end
	end

	// Idle length per request or result, with occasional runs of back-to-back traffic
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(6, 30);
		return $urandom_range(0, 6);
	endfunction

	// Append a request to the driver's queue
	function automatic void add_request(input pdd_req_t c);
		cand_pending.insert(cand_pending.size(), c);
	endfunction

	function automatic bit run_over();
		int unsigned goal;
		goal = (target_reg > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : target_reg;
		return (stored_count >= goal) || (fail_cap != 0 && reject_run >= fail_cap);
	endfunction

	// Decide one candidate against the stored samples and update the state
	function automatic pdd_res_t judge_candidate(input pdd_req_t c);
		point_t       p;
		pdd_res_t     r;
		int unsigned  axes;
		int unsigned  i;
		int unsigned  a;
		logic [35:0]  span;
		logic [15:0]  d;
		bit           clash;
		p = point_t'(c);
		r = '0;
		items_sent++;
		axes = (dims_reg == 0) ? 1 : ((dims_reg > AXES_TOP) ? AXES_TOP : dims_reg);
		if (!run_over()) begin
			clash = 1'b0;
			for (i = 0; i < stored_count && !clash; i++) begin
				span = '0;
				for (a = 0; a < axes; a++) begin
					d = (sites[i][a] >= p[a]) ? sites[i][a] - p[a] : p[a] - sites[i][a];
					span += d * d;
				end
				if (span < min_gap_sq)
					clash = 1'b1;
			end
			if (!clash) begin
				r.accepted = 1'b1;
				r.slot_index = stored_count[SLOT_W-1:0];
				sites[stored_count] = p;
				stored_count++;
				reject_run = '0;
			end else if (reject_run != FAIL_MAX) begin
				reject_run++;
			end
		end
		r.count_now = stored_count;
		r.failures_now = reject_run;
		r.finished = run_over();
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid <= 1'b0;
			cand <= '0;
			cand_live = 1'b0;
			cand_gap = 0;
		end else begin
			if (cand_valid && cand_ready) begin
				verdicts_due.insert(verdicts_due.size(), judge_candidate(cand));
				cand_live = 1'b0;
				cand_gap = draw_gap(cand_calm);
			end
			if (!cand_live) begin
				if (cand_gap > 0) begin
					cand_gap--;
				end else if (cand_pending.size() != 0) begin
					cand <= cand_pending.pop_front();
					cand_live = 1'b1;
				end
			end
			cand_valid <= cand_live;
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		pdd_res_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result with no request pending: %h", res);
					mismatches++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("accepted", want.accepted, res.accepted);
					check_field("slot_index", want.slot_index, res.slot_index);
					check_field("count_now", want.count_now, res.count_now);
					check_field("failures_now", want.failures_now, res.failures_now);
					check_field("finished", want.finished, res.finished);
				end
				hold_cycles = draw_gap(res_calm);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Wait until every request has been taken and every result has come back
	task automatic settle();
		do @(posedge clk);
		while (cand_pending.size() != 0 || cand_live || verdicts_due.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MIN_DIST: min_gap_sq = val;
			REG_LIMIT:    fail_cap = val[LIMIT_W-1:0];
			REG_TARGET:   target_reg = val[TARGET_W-1:0];
			REG_DIMS:     dims_reg = val[DIMS_W-1:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		point_t pt;
		int     reach;
		int     n;
		int     k;
		int     a;
		int     v;
		bit     edge_hit;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero spacing: duplicates and corners all go in
		add_request(pdd_req_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		add_request(pdd_req_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		add_request(pdd_req_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		settle();

		// Spacing beyond any reachable distance rejects everything
		write_reg(REG_MIN_DIST, DIST_TOP);
		write_reg(REG_DIMS, CFG_DATA_W'(4));
		add_request(pdd_req_t'{16'h8000, 16'h8000, 16'h8000, 16'h8000});
		settle();
		write_reg(REG_MIN_DIST, '1);
		add_request(pdd_req_t'{16'h1234, 16'hEDCB, 16'h5A5A, 16'hA5A5});
		settle();

		// Failure limit lowered below the current run: finished, request dropped
		write_reg(REG_LIMIT, CFG_DATA_W'(1));
		add_request(pdd_req_t'{16'h4000, 16'h4000, 16'h4000, 16'h4000});
		settle();

		// Distance equal to the spacing passes, one below fails; dims 0 acts as 1
		write_reg(REG_LIMIT, '0);
		write_reg(REG_MIN_DIST, CFG_DATA_W'(32'h0100_0000));
		write_reg(REG_DIMS, '0);
		add_request(pdd_req_t'{16'h1000, 16'h5555, 16'hAAAA, 16'h0F0F});
		add_request(pdd_req_t'{16'h0FFF, 16'hF0F0, 16'h3333, 16'hCCCC});
		settle();

		// Dims above the bound clamp to four
		write_reg(REG_DIMS, CFG_DATA_W'(7));
		add_request(pdd_req_t'{16'h0800, 16'h0800, 16'h0800, 16'h0800});
		add_request(pdd_req_t'{16'h07FF, 16'h0800, 16'h0800, 16'h0800});
		settle();
		write_reg(REG_DIMS, CFG_DATA_W'(3));
		add_request(pdd_req_t'{16'hC000, 16'h3000, 16'h9000, 16'h0001});
		settle();
		write_reg(REG_DIMS, CFG_DATA_W'(5));
		add_request(pdd_req_t'{16'h6000, 16'hB000, 16'h2000, 16'hFFFE});
		settle();

		// Target zero: finished from the start
		write_reg(REG_TARGET, '0);
		add_request(pdd_req_t'{16'h7777, 16'h8888, 16'h9999, 16'hAAAA});
		add_request(pdd_req_t'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
		settle();

		// Target above capacity
		write_reg(REG_TARGET, CFG_DATA_W'(2047));
		write_reg(REG_DIMS, CFG_DATA_W'(1));
		add_request(pdd_req_t'{16'h3800, 16'h1111, 16'h2222, 16'h4444});
		settle();

		// Reach the target exactly, then one more is dropped
		write_reg(REG_TARGET, CFG_DATA_W'(stored_count + 1));
		write_reg(REG_DIMS, CFG_DATA_W'(2));
		add_request(pdd_req_t'{16'hA000, 16'h6000, 16'h0000, 16'h0000});
		add_request(pdd_req_t'{16'h2000, 16'hE000, 16'h0000, 16'h0000});
		settle();

		write_reg(REG_LIMIT, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_TARGET, CFG_DATA_W'(DEF_MAX_SAMPLES));
		add_request(pdd_req_t'{16'hE000, 16'h2000, 16'h7000, 16'h1000});
		settle();

		// Random phases, each with a fresh register setting
		while (items_sent < ITEM_GOAL) begin
			reach = $urandom_range(16'h0200, 16'h3000);
			case ($urandom_range(0, 9))
				0:       write_reg(REG_MIN_DIST, '0);
				1:       write_reg(REG_MIN_DIST, $urandom_range(0, 1) ? DIST_TOP : '1);
				default: write_reg(REG_MIN_DIST, CFG_DATA_W'(reach * reach));
			endcase
			case ($urandom_range(0, 3))
				0:       write_reg(REG_LIMIT, '0);
				1:       write_reg(REG_LIMIT, CFG_DATA_W'($urandom_range(1, 8)));
				2:       write_reg(REG_LIMIT, CFG_DATA_W'($urandom_range(9, 400)));
				default: write_reg(REG_LIMIT, CFG_DATA_W'(16'hFFFF));
			endcase
			case ($urandom_range(0, 4))
				0:       write_reg(REG_TARGET, CFG_DATA_W'(2047));
				1:       write_reg(REG_TARGET, CFG_DATA_W'(DEF_MAX_SAMPLES));
				default: write_reg(REG_TARGET,
						CFG_DATA_W'(stored_count + $urandom_range(1, 30)));
			endcase
			write_reg(REG_DIMS, CFG_DATA_W'($urandom_range(0, 7)));

			n = $urandom_range(8, 40);
			repeat (n) begin
				pt = point_t'({$urandom, $urandom});
				// Half the points land near a stored sample to probe the spacing edge
				if (stored_count != 0 && $urandom_range(0, 9) < 5) begin
					k = $urandom_range(0, stored_count - 1);
					edge_hit = ($urandom_range(0, 3) == 0);
					for (a = 0; a < NUM_FIELDS; a++) begin
						v = sites[k][a];
						if (edge_hit)
							v = v + ((a == 0) ? reach : 0);
						else
							v = v + int'($urandom_range(0, 2 * reach)) - reach;
						pt[a] = (v < 0) ? 16'h0000 : ((v > 16'hFFFF) ? 16'hFFFF : v[15:0]);
					end
				end
				add_request(pdd_req_t'(pt));
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("poisson_disk_dart_throwing test passed");
		else
			$display("poisson_disk_dart_throwing test failed");
		$finish;
	end

endmodule

[files.f]
rtl/pdd_pkg.sv
rtl/pdd_store.sv
rtl/pdd_cell.sv
rtl/poisson_disk_dart_throwing.sv
test/testbench.sv
